/* rtl/ft3d_pkg.sv */
// Shared types and constants for the three-dimensional Fenwick tree block.
// Holds the item and result payload structs, the item kind codes and the
// configuration register indexes. Depends on nothing.
`timescale 1ns / 1ps

package ft3d_pkg;

  // Width of an input coordinate field and of a grid dimension register.
  localparam int FW = 5;
  // Internal coordinate width: one bit wider, so that i | (i + 1) never wraps.
  localparam int CW = FW + 1;
  // Width of a tree word and of the value and sum fields.
  localparam int DW = 32;

  localparam int DEF_MAX_DIM = 16;
  localparam logic [FW-1:0] DIM_RESET = 5'd16;

  // Item kinds.
  localparam logic [1:0] K_POINT = 2'd0;
  localparam logic [1:0] K_BOX   = 2'd1;
  localparam logic [1:0] K_QUERY = 2'd2;
  localparam logic [1:0] K_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DIM_Z = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [FW-1:0]        begin_x;
    logic [FW-1:0]        begin_y;
    logic [FW-1:0]        begin_z;
    logic [FW-1:0]        end_x;
    logic [FW-1:0]        end_y;
    logic [FW-1:0]        end_z;
    logic signed [DW-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] sum;
    logic                 range_error;
  } result_t;

  // Grid dimensions in use, already clamped to 1..MAX_DIM.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } dims_t;

endpackage

/* rtl/fenwick_tree_3d_box_sum.sv */
// Three-dimensional Fenwick tree of 32-bit wrapping counts over a configurable grid
// of up to MAX_DIM cells per axis, kept in one MAX_DIM^3-word memory. One item is
// handled at a time. A point add touches up to L^3 tree words (L = floor(log2(n)) + 1
// along an axis of size n), and every word is read, then written back. A box add
// costs that for each cell of the clipped box. A box sum query reads the words of
// eight prefix sums, one read per cycle, at most 8 * L'^3 reads in all, where L' is
// the longest prefix walk along an axis (4 for a 16-cell axis). A clear, a dimension
// write and reset all start a clearing pass over all MAX_DIM^3 words (4096 at the
// default), during which no item is taken; dimension writes are taken at all times.
// Every item that no dimension write cuts short gives one result; queries beyond the
// grid flag range_error. Depends on ft3d_pkg, ft3d_store and ft3d_ctrl.
`timescale 1ns / 1ps

module fenwick_tree_3d_box_sum #(
  parameter int MAX_DIM = ft3d_pkg::DEF_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ft3d_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ft3d_pkg::FW-1:0]     cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ft3d_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output ft3d_pkg::result_t           result
);

  localparam int DEPTH = MAX_DIM ** 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ft3d_pkg::CW;
  localparam int FW    = ft3d_pkg::FW;
  localparam int DW    = ft3d_pkg::DW;

  logic [FW-1:0]     dim_x, dim_y, dim_z;
  ft3d_pkg::dims_t   dims;
  logic              wipe;
  logic              res_free, res_load;
  ft3d_pkg::result_t res_data;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DW-1:0]     mem_wdata, mem_rdata;

  // A zero dimension acts as one; anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [CW-1:0] used_dim(input logic [FW-1:0] d);
    if (d == '0) begin
      return CW'(1);
    end else if (int'(d) > MAX_DIM) begin
      return CW'(MAX_DIM);
    end else begin
      return {1'b0, d};
    end
  endfunction

  assign dims.x = used_dim(dim_x);
  assign dims.y = used_dim(dim_y);
  assign dims.z = used_dim(dim_z);

  // The tree layout depends on the grid size, so any dimension write clears the store.
  assign wipe = cfg_write && ((cfg_index == ft3d_pkg::CFG_DIM_X) ||
                              (cfg_index == ft3d_pkg::CFG_DIM_Y) ||
                              (cfg_index == ft3d_pkg::CFG_DIM_Z));

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= ft3d_pkg::DIM_RESET;
      dim_y <= ft3d_pkg::DIM_RESET;
      dim_z <= ft3d_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ft3d_pkg::CFG_DIM_X: dim_x <= cfg_data;
        ft3d_pkg::CFG_DIM_Y: dim_y <= cfg_data;
        ft3d_pkg::CFG_DIM_Z: dim_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: a finished result waits here until its transfer.
  assign res_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_data;
    end
  end

  ft3d_ctrl #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .wipe       (wipe),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_free   (res_free),
    .res_load   (res_load),
    .res_data   (res_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ft3d_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/ft3d_store.sv */
// Tree word memory: one write port and one read port with registered read data.
// Uses ft3d_pkg for the word width.
`timescale 1ns / 1ps

module ft3d_store #(
  parameter int DEPTH = ft3d_pkg::DEF_MAX_DIM ** 3,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [ft3d_pkg::DW-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [ft3d_pkg::DW-1:0] rdata
);

  logic [ft3d_pkg::DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ft3d_ctrl.sv */
// Sequencer of the Fenwick tree: clearing sweep, read-modify-write update walks
// for point and box adds, and the eight prefix-sum read walks of a box query.
// Uses ft3d_pkg and drives the ports of ft3d_store.
`timescale 1ns / 1ps

module ft3d_ctrl #(
  parameter int MAX_DIM = ft3d_pkg::DEF_MAX_DIM,
  parameter int DEPTH   = MAX_DIM ** 3,
  parameter int AW      = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ft3d_pkg::dims_t         dims,
  input  logic                    wipe,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  ft3d_pkg::item_t         item,
  input  logic                    res_free,
  output logic                    res_load,
  output ft3d_pkg::result_t       res_data,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [ft3d_pkg::DW-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  logic [ft3d_pkg::DW-1:0] mem_rdata
);

  localparam int CW = ft3d_pkg::CW;
  localparam int DW = ft3d_pkg::DW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WR    = 7'b0001000,
    S_QRY   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] sweep;
  logic          clr_reply;
  logic [CW-1:0] bx, by, bz, ex, ey, ez;
  logic [CW-1:0] lx, ly, lz;
  logic [CW-1:0] cx, cy, cz;
  logic [CW-1:0] ux, uy, uz;
  logic [DW-1:0] value;
  logic [2:0]    corner;
  logic          rd_pend, rd_neg;
  logic [DW-1:0] acc;
  logic          err;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] i, input logic [CW-1:0] j,
                                               input logic [CW-1:0] k);
    return AW'(i) + AW'(j) * AW'(MAX_DIM) + AW'(k) * AW'(MAX_DIM * MAX_DIM);
  endfunction

  // Accept-side decode.
  logic          accept;
  logic [CW-1:0] in_bx, in_by, in_bz, in_ex, in_ey, in_ez;
  logic [CW-1:0] ax, ay, az, in_lx, in_ly, in_lz;
  logic          box_empty, query_bad;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  always_comb begin
    in_bx = {1'b0, item.begin_x};
    in_by = {1'b0, item.begin_y};
    in_bz = {1'b0, item.begin_z};
    in_ex = {1'b0, item.end_x};
    in_ey = {1'b0, item.end_y};
    in_ez = {1'b0, item.end_z};
    // A point add is a box add of one cell; either way the end is clipped to the grid.
    ax = (item.kind == ft3d_pkg::K_POINT) ? in_bx + CW'(1) : in_ex;
    ay = (item.kind == ft3d_pkg::K_POINT) ? in_by + CW'(1) : in_ey;
    az = (item.kind == ft3d_pkg::K_POINT) ? in_bz + CW'(1) : in_ez;
    in_lx = (ax < dims.x) ? ax : dims.x;
    in_ly = (ay < dims.y) ? ay : dims.y;
    in_lz = (az < dims.z) ? az : dims.z;
    box_empty = (in_bx >= in_lx) || (in_by >= in_ly) || (in_bz >= in_lz);
    query_bad = (in_bx > dims.x) || (in_by > dims.y) || (in_bz > dims.z) ||
                (in_ex > dims.x) || (in_ey > dims.y) || (in_ez > dims.z);
  end

  // Update walk: next tree word of the current cell, then the next cell of the box.
  logic [CW-1:0] upd_x, upd_y, upd_z, cell_x, cell_y, cell_z;
  logic          upd_last, box_last;

  always_comb begin
    upd_x    = ux;
    upd_y    = uy;
    upd_z    = uz;
    cell_x   = cx;
    cell_y   = cy;
    cell_z   = cz;
    upd_last = 1'b0;
    box_last = 1'b0;
    if ((uz | (uz + CW'(1))) < dims.z) begin
      upd_z = uz | (uz + CW'(1));
    end else begin
      upd_z = cz;
      if ((uy | (uy + CW'(1))) < dims.y) begin
        upd_y = uy | (uy + CW'(1));
      end else begin
        upd_y = cy;
        if ((ux | (ux + CW'(1))) < dims.x) begin
          upd_x = ux | (ux + CW'(1));
        end else begin
          upd_last = 1'b1;
        end
      end
    end
    if (upd_last) begin
      if (cz + CW'(1) < lz) begin
        cell_z = cz + CW'(1);
      end else begin
        cell_z = bz;
        if (cy + CW'(1) < ly) begin
          cell_y = cy + CW'(1);
        end else begin
          cell_y = by;
          if (cx + CW'(1) < lx) begin
            cell_x = cx + CW'(1);
          end else begin
            box_last = 1'b1;
          end
        end
      end
      upd_x = cell_x;
      upd_y = cell_y;
      upd_z = cell_z;
    end
  end

  // Query walk. The iterators hold index + 1, so that a prefix of zero length
  // shows as a zero iterator and the step is u & (u - 1).
  logic [CW-1:0] qry_x, qry_y, qry_z;
  logic [2:0]    corner_next;
  logic          q_live, corner_end, corner_last, q_read;

  always_comb begin
    qry_x       = ux;
    qry_y       = uy;
    qry_z       = uz;
    corner_next = corner;
    corner_end  = 1'b0;
    corner_last = 1'b0;
    q_live      = (ux != '0) && (uy != '0) && (uz != '0);
    if (q_live) begin
      if ((uz & (uz - CW'(1))) != '0) begin
        qry_z = uz & (uz - CW'(1));
      end else begin
        qry_z = corner[2] ? bz : ez;
        if ((uy & (uy - CW'(1))) != '0) begin
          qry_y = uy & (uy - CW'(1));
        end else begin
          qry_y = corner[1] ? by : ey;
          if ((ux & (ux - CW'(1))) != '0) begin
            qry_x = ux & (ux - CW'(1));
          end else begin
            corner_end = 1'b1;
          end
        end
      end
    end else begin
      corner_end = 1'b1;
    end
    if (corner_end) begin
      corner_next = corner + 3'd1;
      corner_last = (corner == 3'd7);
      qry_x = corner_next[0] ? bx : ex;
      qry_y = corner_next[1] ? by : ey;
      qry_z = corner_next[2] ? bz : ez;
    end
  end

  assign q_read = (state == S_QRY) && q_live;

  // Memory port drive.
  always_comb begin
    mem_re    = (state == S_RD) || q_read;
    mem_raddr = (state == S_QRY) ? cell_addr(ux - CW'(1), uy - CW'(1), uz - CW'(1))
                                 : cell_addr(ux, uy, uz);
    mem_we    = (state == S_WR) || (state == S_CLEAR);
    mem_waddr = (state == S_CLEAR) ? sweep : cell_addr(ux, uy, uz);
    mem_wdata = (state == S_CLEAR) ? '0 : mem_rdata + value;
  end

  assign res_load          = (state == S_DONE) && res_free;
  assign res_data.sum      = acc;
  assign res_data.range_error = err;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.kind)
            ft3d_pkg::K_POINT, ft3d_pkg::K_BOX: state_next = box_empty ? S_DONE : S_RD;
            ft3d_pkg::K_QUERY: state_next = query_bad ? S_DONE : S_QRY;
            default: state_next = S_CLEAR;
          endcase
        end
      end
      S_CLEAR: begin
        if (sweep == LAST_ADDR) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_RD:    state_next = S_WR;
      S_WR:    state_next = box_last ? S_DONE : S_RD;
      S_QRY: begin
        if (corner_end && corner_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (wipe) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      clr_reply <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= q_read;
      if (wipe) begin
        sweep     <= '0;
        clr_reply <= 1'b0;
      end else if (state == S_CLEAR) begin
        sweep <= sweep + AW'(1);
      end else if (accept) begin
        sweep     <= '0;
        clr_reply <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_neg <= ^corner;
    if (accept) begin
      bx     <= in_bx;
      by     <= in_by;
      bz     <= in_bz;
      ex     <= in_ex;
      ey     <= in_ey;
      ez     <= in_ez;
      lx     <= in_lx;
      ly     <= in_ly;
      lz     <= in_lz;
      cx     <= in_bx;
      cy     <= in_by;
      cz     <= in_bz;
      value  <= $unsigned(item.value);
      corner <= 3'd0;
      acc    <= '0;
      err    <= (item.kind == ft3d_pkg::K_QUERY) && query_bad;
      if (item.kind == ft3d_pkg::K_QUERY) begin
        ux <= in_ex;
        uy <= in_ey;
        uz <= in_ez;
      end else begin
        ux <= in_bx;
        uy <= in_by;
        uz <= in_bz;
      end
    end else begin
      if (rd_pend) begin
        acc <= rd_neg ? acc - mem_rdata : acc + mem_rdata;
      end
      if (state == S_WR) begin
        cx <= cell_x;
        cy <= cell_y;
        cz <= cell_z;
        ux <= upd_x;
        uy <= upd_y;
        uz <= upd_z;
      end else if (state == S_QRY) begin
        corner <= corner_next;
        ux     <= qry_x;
        uy     <= qry_y;
        uz     <= qry_z;
      end
    end
  end

endmodule
